// ===== src/tbd_pkg.sv =====
// Shared constants, types and codes for the tremor band detector.
package tbd_pkg;

  localparam int WINDOW_DEF      = 1000;
  localparam int AVG_LEN_DEF     = 50;
  localparam int FAST_PERIOD_DEF = 64;
  localparam int SLOW_PERIOD_DEF = 96;

  localparam int AXIS_W    = 16;
  localparam int TOTAL_W   = 18;
  localparam int LEVEL_W   = 19;
  localparam int OFFSET_W  = 18;
  localparam int SUM_W     = 24;
  localparam int BAND_W    = 10;
  localparam int CROSS_W   = 10;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TICK_W    = 10;
  // the count of times the average walk meets one ring entry, up to 7
  localparam int MULT_W    = 3;

  // adding this is the same as subtracting 32767, one below the axis mid-point, modulo 2^16
  localparam logic [AXIS_W-1:0]   AXIS_SHIFT = 16'd32769;
  localparam logic [TICK_W-1:0]   TICK_WRAP  = 10'd1000;
  localparam logic [SUM_W-1:0]    SUM_MAX    = '1;
  localparam logic [CROSS_W-1:0]  CROSS_MAX  = '1;

  localparam logic [OFFSET_W-1:0] CENTRE_OFFSET_RST = 18'd98221;
  localparam logic [SUM_W-1:0]    HIGH_LEVEL_RST    = 24'd491107;
  localparam logic [SUM_W-1:0]    LOW_LEVEL_RST     = 24'd245553;
  localparam logic [BAND_W-1:0]   BAND_LOW_RST      = 10'd12;
  localparam logic [BAND_W-1:0]   BAND_HIGH_RST     = 10'd24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_OFFSET = 3'd0,
    REG_HIGH_LEVEL    = 3'd1,
    REG_LOW_LEVEL     = 3'd2,
    REG_BAND_LOW      = 3'd3,
    REG_BAND_HIGH     = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // one ring entry as it reaches the scan unit
  typedef struct packed {
    logic                      valid;
    logic [MULT_W-1:0]         mult;
    logic signed [LEVEL_W-1:0] level;
  } scan_ent_t;

endpackage

// ===== src/tbd_scan.sv =====
// Scan unit: saturating weighted level sum and sign-change count, one valid entry a cycle.
module tbd_scan import tbd_pkg::*; #(
  parameter int WINDOW = WINDOW_DEF,
  localparam int CNT_W = $clog2(WINDOW + 1)
) (
  input  logic             clk,
  input  logic             clear,
  input  scan_ent_t        ent,
  output logic [SUM_W-1:0] level_sum,
  output logic [CNT_W-1:0] cross_count
);

  logic                      neg_past;
  logic                      neg_now;
  logic [LEVEL_W-1:0]        mag;
  logic [LEVEL_W+MULT_W-1:0] term;
  logic [SUM_W:0]            sum_wide;
  logic [SUM_W-1:0]          sum_next;

  always_comb begin
    mag = (ent.level < 0) ? $unsigned(-ent.level) : $unsigned(ent.level);
    term = (LEVEL_W + MULT_W)'(mag) * (LEVEL_W + MULT_W)'(ent.mult);
    sum_wide = {1'b0, level_sum} + (SUM_W + 1)'(term);
    sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    // zero keeps the sign seen last
    if (ent.level > 0) begin
      neg_now = 1'b0;
    end else if (ent.level < 0) begin
      neg_now = 1'b1;
    end else begin
      neg_now = neg_past;
    end
  end

  always_ff @(posedge clk) begin
    if (clear) begin
      level_sum   <= '0;
      cross_count <= '0;
      neg_past    <= 1'b0;
    end else if (ent.valid) begin
      level_sum   <= sum_next;
      cross_count <= cross_count + CNT_W'(neg_now != neg_past);
      neg_past    <= neg_now;
    end
  end

endmodule

// ===== src/tremor_band_detector.sv =====
// Tremor band detector. Each accepted gyro word (three axes) is centred, summed and offset
// into a signed level that goes into a WINDOW-entry ring held in a simple dual-port RAM. The
// block then sweeps the ring once, oldest to newest, through one shared accumulate unit:
// each entry adds to the sign-change count and, weighted by how often the newest-AVG_LEN
// walk meets it, to the saturating level sum. The sweep is paced by the one RAM read per
// cycle; sample_stall stays high from the accepted word until the result is loaded. The
// result sits in an output register, so the next sample may be taken while it waits. Ring
// entries not yet written read as level zero via a fill count, so no clearing pass follows
// reset. Configuration registers are written through cfg_we, cfg_index and cfg_data by the
// user, only while idle; the block does not enforce this. Unknown indexes are ignored.
module tremor_band_detector import tbd_pkg::*; #(
  parameter int WINDOW      = WINDOW_DEF,
  parameter int AVG_LEN     = AVG_LEN_DEF,
  parameter int FAST_PERIOD = FAST_PERIOD_DEF,
  parameter int SLOW_PERIOD = SLOW_PERIOD_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  logic [AXIS_W-1:0]    axis_x,
  input  logic [AXIS_W-1:0]    axis_y,
  input  logic [AXIS_W-1:0]    axis_z,
  output logic                 result_valid,
  input  logic                 result_stall,
  output logic                 led,
  output logic [CROSS_W-1:0]   crossings,
  output logic [SUM_W-1:0]     level_sum
);

  localparam int IDX_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int MREP  = (AVG_LEN + WINDOW - 1) / WINDOW;
  localparam int FP_W  = $clog2(FAST_PERIOD);
  localparam int SP_W  = $clog2(SLOW_PERIOD);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);
  localparam logic [FP_W-1:0]  FP_LAST  = FP_W'(FAST_PERIOD - 1);
  localparam logic [SP_W-1:0]  SP_LAST  = SP_W'(SLOW_PERIOD - 1);

  // configuration
  logic [OFFSET_W-1:0] centre_offset;
  logic [SUM_W-1:0]    high_level;
  logic [SUM_W-1:0]    low_level;
  logic [BAND_W-1:0]   band_low;
  logic [BAND_W-1:0]   band_high;

  state_t state, state_next;

  logic [IDX_W-1:0]  write_slot;
  logic [IDX_W-1:0]  slot_next;
  logic [CNT_W-1:0]  fill;
  logic [TICK_W-1:0] tick;
  logic [TICK_W-1:0] tick_next;
  logic [FP_W-1:0]   fast_phase;
  logic [SP_W-1:0]   slow_phase;

  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  age;
  logic [MULT_W-1:0] mult;
  logic              ent_valid_q;
  logic              ent_written_q;
  logic [MULT_W-1:0] ent_mult_q;

  logic signed [LEVEL_W-1:0] ring [WINDOW];
  logic signed [LEVEL_W-1:0] ring_q;

  logic [AXIS_W-1:0]         cx, cy, cz;
  logic [TOTAL_W-1:0]        total;
  logic signed [LEVEL_W-1:0] level_new;

  logic       take;
  logic       scan_issue;
  logic       result_load;
  logic       led_next;
  logic       in_band;
  logic       fast_on;
  logic       slow_on;
  scan_ent_t  ent;
  logic [SUM_W-1:0] scan_sum;
  logic [CNT_W-1:0] scan_cross;

  assign take = sample_valid && !sample_stall;

  // level of the incoming word
  always_comb begin
    cx = axis_x + AXIS_SHIFT;
    cy = axis_y + AXIS_SHIFT;
    cz = axis_z + AXIS_SHIFT;
    total = TOTAL_W'(cx) + TOTAL_W'(cy) + TOTAL_W'(cz);
    level_new = $signed({1'b0, total}) - $signed({1'b0, centre_offset});
  end

  always_comb begin
    slot_next = (write_slot == LAST_IDX) ? '0 : write_slot + IDX_W'(1);
    tick_next = (tick == TICK_WRAP) ? '0 : tick + TICK_W'(1);
  end

  // how many times the newest-AVG_LEN walk lands on the entry of this age
  always_comb begin
    mult = '0;
    for (int k = 0; k < MREP; k++) begin
      if (32'(age) + 32'(k * WINDOW) < 32'(AVG_LEN)) begin
        mult = mult + MULT_W'(1);
      end
    end
  end

  // sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (take) state_next = ST_SCAN;
      ST_SCAN:  if (age == '0) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_DONE;
      ST_DONE:  if (result_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    sample_stall = (state != ST_IDLE);
    scan_issue   = (state == ST_SCAN);
    result_load  = (state == ST_DONE) && (!result_valid || !result_stall);
  end

  // ring RAM
  always_ff @(posedge clk) begin
    if (take) begin
      ring[write_slot] <= level_new;
    end
    ring_q <= ring[rd_addr];
  end

  // sweep address and age, oldest entry first
  always_ff @(posedge clk) begin
    if (take) begin
      rd_addr <= slot_next;
      age     <= LAST_IDX;
    end else if (scan_issue) begin
      rd_addr <= (rd_addr == LAST_IDX) ? '0 : rd_addr + IDX_W'(1);
      age     <= age - IDX_W'(1);
    end
    ent_written_q <= (fill == FULL_CNT) || (CNT_W'(rd_addr) < fill);
    ent_mult_q    <= mult;
  end

  always_comb begin
    ent.valid = ent_valid_q;
    ent.mult  = ent_mult_q;
    ent.level = ent_written_q ? ring_q : '0;
  end

  tbd_scan #(
    .WINDOW (WINDOW)
  ) u_scan (
    .clk         (clk),
    .clear       (take),
    .ent         (ent),
    .level_sum   (scan_sum),
    .cross_count (scan_cross)
  );

  // LED decision
  always_comb begin
    in_band = (32'(scan_cross) > 32'(band_low)) && (32'(scan_cross) < 32'(band_high));
    fast_on = 32'(fast_phase) < 32'(FAST_PERIOD / 2);
    slow_on = 32'(slow_phase) < 32'(SLOW_PERIOD / 2);
    led_next = led;
    if (in_band) begin
      priority if (scan_sum > high_level) begin
        led_next = fast_on;
      end else if (scan_sum > low_level) begin
        led_next = slow_on;
      end else begin
        led_next = 1'b0;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      write_slot   <= '0;
      fill         <= '0;
      tick         <= '0;
      fast_phase   <= '0;
      slow_phase   <= '0;
      ent_valid_q  <= 1'b0;
      result_valid <= 1'b0;
      led          <= 1'b0;
    end else begin
      state       <= state_next;
      ent_valid_q <= scan_issue;
      if (take) begin
        write_slot <= slot_next;
        if (fill != FULL_CNT) begin
          fill <= fill + CNT_W'(1);
        end
        tick <= tick_next;
        if (tick_next == '0) begin
          fast_phase <= '0;
          slow_phase <= '0;
        end else begin
          fast_phase <= (fast_phase == FP_LAST) ? '0 : fast_phase + FP_W'(1);
          slow_phase <= (slow_phase == SP_LAST) ? '0 : slow_phase + SP_W'(1);
        end
      end
      if (result_load) begin
        result_valid <= 1'b1;
        led          <= led_next;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (result_load) begin
      level_sum <= scan_sum;
      crossings <= (32'(scan_cross) > 32'(CROSS_MAX)) ? CROSS_MAX : CROSS_W'(scan_cross);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      centre_offset <= CENTRE_OFFSET_RST;
      high_level    <= HIGH_LEVEL_RST;
      low_level     <= LOW_LEVEL_RST;
      band_low      <= BAND_LOW_RST;
      band_high     <= BAND_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTRE_OFFSET: centre_offset <= cfg_data[OFFSET_W-1:0];
        REG_HIGH_LEVEL:    high_level    <= cfg_data[SUM_W-1:0];
        REG_LOW_LEVEL:     low_level     <= cfg_data[SUM_W-1:0];
        REG_BAND_LOW:      band_low      <= cfg_data[BAND_W-1:0];
        REG_BAND_HIGH:     band_high     <= cfg_data[BAND_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== src/tbd_checker.sv =====
// Port-level checks for the tremor band detector, bound to the top level.
module tbd_checker import tbd_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input logic               result_valid,
  input logic               result_stall,
  input logic               led,
  input logic [CROSS_W-1:0] crossings,
  input logic [SUM_W-1:0]   level_sum
);

  // a waiting result word holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(led) && $stable(crossings) && $stable(level_sum))
    else $error("result word changed while stalled");

  // an accepted word keeps the input side busy at the start of the sweep
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall ##1 sample_stall)
    else $error("input taken again before the sweep finished");

  // a new result only appears out of a busy input side, never straight from idle
  a_result_from_sweep: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(sample_stall))
    else $error("result raised while idle");

endmodule

bind tremor_band_detector tbd_checker u_tbd_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .led          (led),
  .crossings    (crossings),
  .level_sum    (level_sum)
);
